// ===== sv/rtfu_pkg.sv =====
// Shared types, codes and constants for the register-transfer and flag unit.
// No dependencies; every other file in the project imports this package.
package rtfu_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 96;

    // Status byte bit positions: n v m x d i z c
    localparam int FLAG_N = 7;
    localparam int FLAG_V = 6;
    localparam int FLAG_M = 5;
    localparam int FLAG_X = 4;
    localparam int FLAG_D = 3;
    localparam int FLAG_I = 2;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [15:0] RESET_SP    = 16'h01FF;
    localparam logic [7:0]  RESET_FLAGS = 8'h34;

    typedef enum logic [4:0] {
        FN_NOP = 5'd0,
        FN_XBA = 5'd1,
        FN_XCE = 5'd2,
        FN_CLC = 5'd3,
        FN_CLD = 5'd4,
        FN_CLI = 5'd5,
        FN_CLV = 5'd6,
        FN_SEC = 5'd7,
        FN_SED = 5'd8,
        FN_SEI = 5'd9,
        FN_REP = 5'd10,
        FN_SEP = 5'd11,
        FN_TAX = 5'd12,
        FN_TAY = 5'd13,
        FN_TXA = 5'd14,
        FN_TXY = 5'd15,
        FN_TYA = 5'd16,
        FN_TYX = 5'd17,
        FN_TCD = 5'd18,
        FN_TCS = 5'd19,
        FN_TDC = 5'd20,
        FN_TSC = 5'd21,
        FN_TSX = 5'd22,
        FN_TXS = 5'd23
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] operand_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  flags;
        logic        emu;
    } regfile_t;

    // Result beat layout, lowest bit first, zero padded to whole bytes
    function automatic logic [OUT_DATA_W-1:0] pack_result(input regfile_t r);
        return {7'd0, r.emu, r.flags, r.dp, r.sp, r.y, r.x, r.acc};
    endfunction

endpackage

// ===== sv/rtfu_in_stage.sv =====
// Input register of the register-transfer and flag unit.
// Holds one instruction beat until the execute step takes it; uses rtfu_pkg.
module rtfu_in_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rtfu_pkg::IN_DATA_W-1:0] s_tdata,  // [7:0] operand_byte
    input  logic [rtfu_pkg::IN_USER_W-1:0] s_tuser,  // [4:0] func
    input  logic                           advance,
    output logic                           item_valid,
    output rtfu_pkg::item_t                item
);
    import rtfu_pkg::*;

    logic  vld_reg;
    item_t item_reg;

    // Room when empty or when the held beat moves on this cycle
    assign s_tready   = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.func         <= func_t'(s_tuser);
            item_reg.operand_byte <= s_tdata;
        end
    end

endmodule

// ===== sv/rtfu_exec.sv =====
// Execute logic: one register-only instruction applied to the register file.
// Purely combinational; uses rtfu_pkg types and codes.
module rtfu_exec (
    input  rtfu_pkg::item_t    item,
    input  rtfu_pkg::regfile_t cur,
    output rtfu_pkg::regfile_t nxt
);
    import rtfu_pkg::*;

    // Returns {n, z, value}; a narrow move keeps the destination high byte
    function automatic logic [17:0] sized_move(input logic [15:0] dst,
                                               input logic [15:0] src,
                                               input logic        narrow);
        logic [15:0] v;
        begin
            if (narrow)
            begin
                v = {dst[15:8], src[7:0]};
                return {v[7], (v[7:0] == 8'd0), v};
            end
            v = src;
            return {v[15], (v == 16'd0), v};
        end
    endfunction

    logic [17:0] mv;
    logic        xn;
    logic        mn;

    always_comb
    begin
        nxt = cur;
        mv  = '0;
        xn  = cur.flags[FLAG_X];
        mn  = cur.flags[FLAG_M];
        case (item.func)
            FN_NOP: ;
            FN_XBA:
            begin
                nxt.acc          = {cur.acc[7:0], cur.acc[15:8]};
                nxt.flags[FLAG_N] = cur.acc[15];
                nxt.flags[FLAG_Z] = (cur.acc[15:8] == 8'd0);
            end
            FN_XCE:
            begin
                nxt.flags[FLAG_C] = cur.emu;
                nxt.emu           = cur.flags[FLAG_C];
                if (cur.flags[FLAG_C])
                begin
                    nxt.sp            = {STACK_PAGE, cur.sp[7:0]};
                    nxt.flags[FLAG_M] = 1'b1;
                    nxt.flags[FLAG_X] = 1'b1;
                    nxt.x[15:8]       = 8'd0;
                    nxt.y[15:8]       = 8'd0;
                end
            end
            FN_CLC: nxt.flags[FLAG_C] = 1'b0;
            FN_CLD: nxt.flags[FLAG_D] = 1'b0;
            FN_CLI: nxt.flags[FLAG_I] = 1'b0;
            FN_CLV: nxt.flags[FLAG_V] = 1'b0;
            FN_SEC: nxt.flags[FLAG_C] = 1'b1;
            FN_SED: nxt.flags[FLAG_D] = 1'b1;
            FN_SEI: nxt.flags[FLAG_I] = 1'b1;
            FN_REP, FN_SEP:
            begin
                if (item.func == FN_REP)
                begin
                    nxt.flags = cur.flags & ~item.operand_byte;
                end
                else
                begin
                    nxt.flags = cur.flags | item.operand_byte;
                end
                // Emulation pins m and x; narrow index drops the high bytes
                if (cur.emu)
                begin
                    nxt.flags[FLAG_M] = 1'b1;
                    nxt.flags[FLAG_X] = 1'b1;
                end
                if (nxt.flags[FLAG_X])
                begin
                    nxt.x[15:8] = 8'd0;
                    nxt.y[15:8] = 8'd0;
                end
            end
            FN_TAX:
            begin
                mv    = sized_move(cur.x, cur.acc, xn);
                nxt.x = mv[15:0];
            end
            FN_TAY:
            begin
                mv    = sized_move(cur.y, cur.acc, xn);
                nxt.y = mv[15:0];
            end
            FN_TXA:
            begin
                mv      = sized_move(cur.acc, cur.x, mn);
                nxt.acc = mv[15:0];
            end
            FN_TXY:
            begin
                mv    = sized_move(cur.y, cur.x, xn);
                nxt.y = mv[15:0];
            end
            FN_TYA:
            begin
                mv      = sized_move(cur.acc, cur.y, mn);
                nxt.acc = mv[15:0];
            end
            FN_TYX:
            begin
                mv    = sized_move(cur.x, cur.y, xn);
                nxt.x = mv[15:0];
            end
            FN_TCD:
            begin
                mv     = sized_move(cur.dp, cur.acc, 1'b0);
                nxt.dp = mv[15:0];
            end
            FN_TCS:
            begin
                nxt.sp = cur.emu ? {STACK_PAGE, cur.acc[7:0]} : cur.acc;
            end
            FN_TDC:
            begin
                mv      = sized_move(cur.acc, cur.dp, 1'b0);
                nxt.acc = mv[15:0];
            end
            FN_TSC:
            begin
                // Full copy; n and z from the low byte only in emulation
                mv      = sized_move(cur.sp, cur.sp, cur.emu);
                nxt.acc = cur.sp;
            end
            FN_TSX:
            begin
                mv    = sized_move(cur.x, cur.sp, xn);
                nxt.x = mv[15:0];
            end
            FN_TXS:
            begin
                nxt.sp = cur.emu ? {STACK_PAGE, cur.x[7:0]} : cur.x;
            end
            default: ;
        endcase

        case (item.func)
            FN_TAX, FN_TAY, FN_TXA, FN_TXY, FN_TYA, FN_TYX,
            FN_TCD, FN_TDC, FN_TSC, FN_TSX:
            begin
                nxt.flags[FLAG_N] = mv[17];
                nxt.flags[FLAG_Z] = mv[16];
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/rtfu_out_stage.sv =====
// Result register of the register-transfer and flag unit.
// Holds the packed register file until the receiver takes it; uses rtfu_pkg.
module rtfu_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  rtfu_pkg::regfile_t              result,
    output logic                            busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rtfu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rtfu_pkg::*;

    logic                  vld_reg;
    logic [OUT_DATA_W-1:0] data_reg;

    // Full and not drained this cycle
    assign busy     = vld_reg && !m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pack_result(result);
        end
    end

endmodule

// ===== sv/cpu_register_transfer_flag_unit.sv =====
// Top level of the register-transfer and flag unit: input register, execute
// logic, architectural register file and result register. Uses rtfu_pkg.
//
// Usage:
//   Slave channel: one instruction per beat; func in s_tuser, the REP/SEP mask
//   in s_tdata. Master channel: one beat per instruction carrying the whole
//   register file after that instruction.
//   An accepted beat waits in the input register until the result register,
//   which drives m_tvalid, is free. Throughput is one instruction per cycle
//   while the receiver keeps up: the input register, the combinational
//   execute step and the result register form a two-stage pipe, and the
//   register file is updated in the same edge that loads the result register,
//   so the next instruction always sees the state left by the one before.
//   When the receiver stalls, the result register holds its beat, the held
//   instruction waits in the input register and s_tready falls once both are
//   full. It rises again in the cycle the receiver takes the result.
//   Reset empties both stages and loads the power-on register file:
//   A, X, Y, D zero, S 0x01FF, status 0x34 (m, x, i set), emulation on.
module cpu_register_transfer_flag_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rtfu_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] operand_byte
    input  logic [rtfu_pkg::IN_USER_W-1:0]  s_tuser,  // [4:0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] acc_out, [31:16] x_out, [47:32] y_out, [63:48] sp_out,
    // [79:64] dp_out, [87:80] flags_out, [88] emu_out, [95:89] zero
    output logic [rtfu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rtfu_pkg::*;

    item_t    item;
    logic     item_valid;
    logic     out_busy;
    logic     advance;
    regfile_t state_reg;
    regfile_t state_next;

    assign advance = item_valid && !out_busy;

    rtfu_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rtfu_exec u_exec (
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.acc   <= 16'd0;
            state_reg.x     <= 16'd0;
            state_reg.y     <= 16'd0;
            state_reg.sp    <= RESET_SP;
            state_reg.dp    <= 16'd0;
            state_reg.flags <= RESET_FLAGS;
            state_reg.emu   <= 1'b1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    rtfu_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (state_next),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/rtfu_checker.sv =====
// Port-level checks for the register-transfer and flag unit, bound to the top.
// Depends on rtfu_pkg for the result beat layout.
module rtfu_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rtfu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rtfu_pkg::*;

    logic [15:0] x_w;
    logic [15:0] y_w;
    logic [15:0] sp_w;
    logic [7:0]  flags_w;
    logic        emu_w;

    assign x_w     = m_tdata[31:16];
    assign y_w     = m_tdata[47:32];
    assign sp_w    = m_tdata[63:48];
    assign flags_w = m_tdata[87:80];
    assign emu_w   = m_tdata[88];

    a_emu_modes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && emu_w |-> flags_w[FLAG_M] && flags_w[FLAG_X])
        else $error("emulation result without m and x set");

    a_emu_stack_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && emu_w |-> sp_w[15:8] == STACK_PAGE)
        else $error("emulation result with stack outside page one");

    a_narrow_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags_w[FLAG_X] |-> x_w[15:8] == 8'd0 && y_w[15:8] == 8'd0)
        else $error("8-bit index mode with nonzero index high byte");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed or dropped");

endmodule

bind cpu_register_transfer_flag_unit rtfu_checker u_rtfu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_cpu_register_transfer_flag_unit.sv =====
// Self-checking bench for cpu_register_transfer_flag_unit: a directed walk through every
// instruction and mode corner, then random instruction streams under varied idling.
// Depends on rtfu_pkg and the unit's RTL only.
module tb_cpu_register_transfer_flag_unit;
    import rtfu_pkg::*;

    localparam int         PHASE_ITEMS  = 670;
    localparam int         HOLD_AT      = 2 * PHASE_ITEMS + 60;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_LIMIT  = 1000;
    localparam int         MAX_REPORTS  = 10;
    localparam logic [4:0] FN_LAST_CODE = 5'd31;

    typedef struct {
        logic [4:0] fn;
        logic [7:0] opnd;
        bit         typed;
        regfile_t   regs;
    } step_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    regfile_t arch;            // predicted architectural register file
    regfile_t regs_q[$];       // register files still owed by the unit
    step_t    plan[$];
    int       fail_cnt    = 0;
    int       beats_in    = 0;
    int       cycle_cnt   = 0;
    int       tx_idle_pct = 28;
    int       rx_idle_pct = 54;
    int       hold_left   = 0;
    bit       hold_done   = 1'b0;

    cpu_register_transfer_flag_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] operand_byte
        .s_tuser  (s_tuser),   // [4:0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // [15:0] acc, [31:16] x, [47:32] y, [63:48] sp, [79:64] dp, [87:80] flags, [88] emu
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic void note_failure(string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    function automatic void update_nz(logic [15:0] v, logic narrow);
        if (narrow)
        begin
            arch.flags[FLAG_N] = v[7];
            arch.flags[FLAG_Z] = (v[7:0] == 8'h00);
        end
        else
        begin
            arch.flags[FLAG_N] = v[15];
            arch.flags[FLAG_Z] = (v == 16'h0000);
        end
    endfunction

    function automatic logic [15:0] sized_copy(logic [15:0] dst, logic [15:0] src,
                                               logic narrow);
        return narrow ? {dst[15:8], src[7:0]} : src;
    endfunction

    // Emulation pins m and x; an 8-bit index mode drops the index high bytes.
    function automatic void settle_modes();
        if (arch.emu)
        begin
            arch.flags[FLAG_M] = 1'b1;
            arch.flags[FLAG_X] = 1'b1;
        end
        if (arch.flags[FLAG_X])
        begin
            arch.x[15:8] = 8'h00;
            arch.y[15:8] = 8'h00;
        end
    endfunction

    function automatic void run_instr(logic [4:0] fn, logic [7:0] mask);
        logic xn;
        logic mn;
        logic carry;
        xn = arch.flags[FLAG_X];
        mn = arch.flags[FLAG_M];
        case (fn)
            FN_XBA:
            begin
                arch.acc = {arch.acc[7:0], arch.acc[15:8]};
                update_nz(arch.acc, 1'b1);
            end
            FN_XCE:
            begin
                carry = arch.flags[FLAG_C];
                arch.flags[FLAG_C] = arch.emu;
                arch.emu = carry;
                if (arch.emu)
                begin
                    arch.sp = {STACK_PAGE, arch.sp[7:0]};
                    settle_modes();
                end
            end
            FN_CLC: arch.flags[FLAG_C] = 1'b0;
            FN_CLD: arch.flags[FLAG_D] = 1'b0;
            FN_CLI: arch.flags[FLAG_I] = 1'b0;
            FN_CLV: arch.flags[FLAG_V] = 1'b0;
            FN_SEC: arch.flags[FLAG_C] = 1'b1;
            FN_SED: arch.flags[FLAG_D] = 1'b1;
            FN_SEI: arch.flags[FLAG_I] = 1'b1;
            FN_REP:
            begin
                arch.flags = arch.flags & ~mask;
                settle_modes();
            end
            FN_SEP:
            begin
                arch.flags = arch.flags | mask;
                settle_modes();
            end
            FN_TAX:
            begin
                arch.x = sized_copy(arch.x, arch.acc, xn);
                update_nz(arch.x, xn);
            end
            FN_TAY:
            begin
                arch.y = sized_copy(arch.y, arch.acc, xn);
                update_nz(arch.y, xn);
            end
            FN_TXA:
            begin
                arch.acc = sized_copy(arch.acc, arch.x, mn);
                update_nz(arch.acc, mn);
            end
            FN_TXY:
            begin
                arch.y = sized_copy(arch.y, arch.x, xn);
                update_nz(arch.y, xn);
            end
            FN_TYA:
            begin
                arch.acc = sized_copy(arch.acc, arch.y, mn);
                update_nz(arch.acc, mn);
            end
            FN_TYX:
            begin
                arch.x = sized_copy(arch.x, arch.y, xn);
                update_nz(arch.x, xn);
            end
            FN_TCD:
            begin
                arch.dp = arch.acc;
                update_nz(arch.dp, 1'b0);
            end
            FN_TCS: arch.sp = arch.emu ? {STACK_PAGE, arch.acc[7:0]} : arch.acc;
            FN_TDC:
            begin
                arch.acc = arch.dp;
                update_nz(arch.acc, 1'b0);
            end
            FN_TSC:
            begin
                arch.acc = arch.sp;
                update_nz(arch.acc, arch.emu);
            end
            FN_TSX:
            begin
                arch.x = sized_copy(arch.x, arch.sp, xn);
                update_nz(arch.x, xn);
            end
            FN_TXS: arch.sp = arch.emu ? {STACK_PAGE, arch.x[7:0]} : arch.x;
            default: ;
        endcase
    endfunction

    task automatic add_step(input logic [4:0] fn, input logic [7:0] opnd,
                            input bit typed = 1'b0, input regfile_t regs = '0);
        step_t row;
        row.fn    = fn;
        row.opnd  = opnd;
        row.typed = typed;
        row.regs  = regs;
        plan.push_back(row);
    endtask

    // Entered and left at a falling edge; valid stays high between back-to-back beats.
    task automatic send_beat(input logic [4:0] fn, input logic [7:0] opnd,
                             input bit typed = 1'b0, input regfile_t regs = '0);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= opnd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        run_instr(fn, opnd);
        beats_in++;
        regs_q.push_back(typed ? regs : arch);
        @(negedge clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off to fill the pipe.
    always @(negedge clk)
    begin
        if (!hold_done && beats_in >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        regfile_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (regs_q.size() == 0)
            begin
                note_failure($sformatf("result beat with nothing outstanding: %h",
                                       m_tdata));
            end
            else
            begin
                want = regs_q.pop_front();
                check_field("acc", want.acc, m_tdata[15:0]);
                check_field("x", want.x, m_tdata[31:16]);
                check_field("y", want.y, m_tdata[47:32]);
                check_field("sp", want.sp, m_tdata[63:48]);
                check_field("dp", want.dp, m_tdata[79:64]);
                check_field("flags", {8'h00, want.flags}, {8'h00, m_tdata[87:80]});
                check_field("emu", {15'd0, want.emu}, {15'd0, m_tdata[88]});
                check_field("pad", 16'h0000, {9'd0, m_tdata[95:89]});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int drain;
        arch = {16'h0000, 16'h0000, 16'h0000, RESET_SP, 16'h0000, RESET_FLAGS, 1'b1};

        // Power-on state, unused code, masks under emulation, stack to accumulator
        add_step(FN_NOP, 8'h00, 1'b1,
                 {16'h0000, 16'h0000, 16'h0000, 16'h01FF, 16'h0000, 8'h34, 1'b1});
        add_step(FN_LAST_CODE, 8'hFF, 1'b1,
                 {16'h0000, 16'h0000, 16'h0000, 16'h01FF, 16'h0000, 8'h34, 1'b1});
        add_step(FN_SEP, 8'hFF, 1'b1,
                 {16'h0000, 16'h0000, 16'h0000, 16'h01FF, 16'h0000, 8'hFF, 1'b1});
        add_step(FN_REP, 8'hFF, 1'b1,
                 {16'h0000, 16'h0000, 16'h0000, 16'h01FF, 16'h0000, 8'h30, 1'b1});
        add_step(FN_TSC, 8'h00, 1'b1,
                 {16'h01FF, 16'h0000, 16'h0000, 16'h01FF, 16'h0000, 8'hB0, 1'b1});
        // Narrow transfer, byte swap, stack writes held to page one
        add_step(FN_TAX, 8'hA5);
        add_step(FN_XBA, 8'h5A);
        add_step(FN_TCS, 8'hFF);
        add_step(FN_TXS, 8'h00);
        // Leave emulation, widen everything, then every wide transfer but TAX and TCS
        add_step(FN_XCE, 8'h00);
        add_step(FN_REP, 8'h30);
        add_step(FN_TSC, 8'h00);
        add_step(FN_TXS, 8'h00);
        add_step(FN_TSX, 8'h00);
        add_step(FN_TAY, 8'h00);
        add_step(FN_TXY, 8'h00);
        add_step(FN_TYA, 8'h00);
        add_step(FN_TYX, 8'h00);
        add_step(FN_TXA, 8'h00);
        add_step(FN_TCD, 8'h00);
        add_step(FN_TDC, 8'h00);
        // Narrow the indices again, then walk the single-flag operations
        add_step(FN_SEP, 8'hF0);
        add_step(FN_CLV, 8'h00);
        add_step(FN_SED, 8'h00);
        add_step(FN_CLD, 8'h00);
        add_step(FN_SEI, 8'h00);
        add_step(FN_CLI, 8'h00);
        add_step(FN_SEC, 8'h00);
        add_step(FN_CLC, 8'h00);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_beat(plan[i].fn, plan[i].opnd, plan[i].typed, plan[i].regs);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 28;
                    rx_idle_pct <= 54;
                end
                1:
                begin
                    tx_idle_pct = 54;
                    rx_idle_pct <= 28;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_beat(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the two-stage pipe to settle
        drain = 0;
        while (regs_q.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (regs_q.size() != 0)
            note_failure($sformatf("%0d register files never returned", regs_q.size()));

        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
